/* src/spq_pkg.sv */
// spq_pkg: shared types, codes and default sizes for the stable sorted priority queue
// no dependencies; used by spq_cell, stable_sorted_priority_queue, spq_checker and the bench
`default_nettype none

package spq_pkg;

  localparam int DefQueueDepth    = 16;
  localparam int DefTagBits       = 16;
  localparam int DefPriorityBits  = 8;

  localparam int STATUS_BITS = 2;

  // opcode values
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // status codes
  localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

  // per-cycle command seen by every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* src/stable_sorted_priority_queue.sv */
// stable_sorted_priority_queue: a word is accepted every cycle (busy stays low)
// the result appears with done in the cycle after start and lasts one cycle
// a row of QUEUE_DEPTH cells compares and shifts in parallel on each push and pop
// synchronous active-high rst empties the queue; slot contents are not cleared
`default_nettype none

module stable_sorted_priority_queue #(
  parameter int QUEUE_DEPTH   = spq_pkg::DefQueueDepth,
  parameter int TAG_BITS      = spq_pkg::DefTagBits,
  parameter int PRIORITY_BITS = spq_pkg::DefPriorityBits,
  localparam int OCC_BITS     = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire                                opcode,
  input  wire [TAG_BITS-1:0]                 entry_tag,
  input  wire [PRIORITY_BITS-1:0]            entry_priority,
  output logic                               done,
  output logic [spq_pkg::STATUS_BITS-1:0]    status,
  output logic [TAG_BITS-1:0]                popped_tag,
  output logic [PRIORITY_BITS-1:0]           popped_priority,
  output logic [OCC_BITS-1:0]                occupancy
);
  import spq_pkg::*;

  localparam logic [OCC_BITS-1:0] FULL_COUNT = OCC_BITS'(QUEUE_DEPTH);

  logic                     accept;
  logic                     is_full;
  logic                     is_empty;
  cell_ctl_t                ctl;
  logic [OCC_BITS-1:0]      count;
  logic [OCC_BITS-1:0]      count_next;
  logic [STATUS_BITS-1:0]   status_next;

  logic [QUEUE_DEPTH-1:0]   occ;
  logic [QUEUE_DEPTH-1:0]   ahead;
  logic [TAG_BITS-1:0]      cell_tag [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] cell_pri [QUEUE_DEPTH];

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count == FULL_COUNT);
  assign is_empty = (count == '0);

  assign ctl.push = accept && (opcode == OP_PUSH) && !is_full;
  assign ctl.pop  = accept && (opcode == OP_POP) && !is_empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                     lb;
    logic [TAG_BITS-1:0]      lt;
    logic [PRIORITY_BITS-1:0] lp;
    logic [TAG_BITS-1:0]      rt;
    logic [PRIORITY_BITS-1:0] rp;

    assign occ[i] = (count > OCC_BITS'(i));

    // nothing sits left of the head, so a head cell that yields takes the new entry
    if (i == 0) begin : g_head
      assign lb = 1'b1;
      assign lt = '0;
      assign lp = '0;
    end else begin : g_body
      assign lb = ahead[i-1];
      assign lt = cell_tag[i-1];
      assign lp = cell_pri[i-1];
    end

    // tail cell keeps its own contents on a pop
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign rt = cell_tag[i];
      assign rp = cell_pri[i];
    end else begin : g_mid
      assign rt = cell_tag[i+1];
      assign rp = cell_pri[i+1];
    end

    spq_cell #(
      .TAG_BITS      (TAG_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk            (clk),
      .ctl            (ctl),
      .occupied       (occ[i]),
      .new_tag        (entry_tag),
      .new_priority   (entry_priority),
      .left_ahead     (lb),
      .left_tag       (lt),
      .left_priority  (lp),
      .right_tag      (rt),
      .right_priority (rp),
      .ahead          (ahead[i]),
      .tag            (cell_tag[i]),
      .priority_q     (cell_pri[i])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = ST_DONE;
    if (ctl.push) begin
      count_next = count + OCC_BITS'(1);
    end else if (ctl.pop) begin
      count_next = count - OCC_BITS'(1);
    end
    if (opcode == OP_PUSH && is_full) begin
      status_next = ST_FULL;
    end else if (opcode == OP_POP && is_empty) begin
      status_next = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status          <= status_next;
      popped_tag      <= ctl.pop ? cell_tag[0] : '0;
      popped_priority <= ctl.pop ? cell_pri[0] : '0;
    end
  end

  assign occupancy = count;

endmodule

`default_nettype wire

/* src/spq_cell.sv */
// spq_cell: one slot of the sorted shift queue, holds a tag and a priority
// depends on spq_pkg for the command struct
`default_nettype none

module spq_cell #(
  parameter int TAG_BITS      = spq_pkg::DefTagBits,
  parameter int PRIORITY_BITS = spq_pkg::DefPriorityBits
) (
  input  wire                      clk,
  input  spq_pkg::cell_ctl_t       ctl,
  input  wire                      occupied,
  input  wire [TAG_BITS-1:0]       new_tag,
  input  wire [PRIORITY_BITS-1:0]  new_priority,
  input  wire                      left_ahead,
  input  wire [TAG_BITS-1:0]       left_tag,
  input  wire [PRIORITY_BITS-1:0]  left_priority,
  input  wire [TAG_BITS-1:0]       right_tag,
  input  wire [PRIORITY_BITS-1:0]  right_priority,
  output logic                     ahead,
  output logic [TAG_BITS-1:0]      tag,
  output logic [PRIORITY_BITS-1:0] priority_q
);
  import spq_pkg::*;

  logic [TAG_BITS-1:0]      tag_next;
  logic [PRIORITY_BITS-1:0] priority_next;

  // stored entry stays ahead of the new one (ties keep arrival order)
  assign ahead = occupied && (priority_q <= new_priority);

  always_comb begin
    tag_next      = tag;
    priority_next = priority_q;
    if (ctl.pop) begin
      tag_next      = right_tag;
      priority_next = right_priority;
    end else if (ctl.push && !ahead) begin
      if (left_ahead) begin
        tag_next      = new_tag;
        priority_next = new_priority;
      end else begin
        tag_next      = left_tag;
        priority_next = left_priority;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag        <= tag_next;
    priority_q <= priority_next;
  end

endmodule

`default_nettype wire

/* src/spq_checker.sv */
// spq_checker: port-level checks on the stable sorted priority queue
// depends on spq_pkg for status codes; bound to stable_sorted_priority_queue below
`default_nettype none

module spq_checker #(
  parameter int QUEUE_DEPTH   = spq_pkg::DefQueueDepth,
  parameter int TAG_BITS      = spq_pkg::DefTagBits,
  parameter int PRIORITY_BITS = spq_pkg::DefPriorityBits,
  localparam int OCC_BITS     = $clog2(QUEUE_DEPTH + 1)
) (
  input wire                             clk,
  input wire                             rst,
  input wire                             start,
  input wire                             busy,
  input wire                             done,
  input wire [spq_pkg::STATUS_BITS-1:0]  status,
  input wire [TAG_BITS-1:0]              popped_tag,
  input wire [PRIORITY_BITS-1:0]         popped_priority,
  input wire [OCC_BITS-1:0]              occupancy
);
  import spq_pkg::*;

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without an accepted word");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (occupancy == '0))
    else $error("empty status with entries held");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (occupancy == OCC_BITS'(QUEUE_DEPTH)))
    else $error("full status with room left");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_DONE) |-> (popped_tag == '0 && popped_priority == '0))
    else $error("payload not zero on a failed step");

endmodule

bind stable_sorted_priority_queue spq_checker #(
  .QUEUE_DEPTH   (QUEUE_DEPTH),
  .TAG_BITS      (TAG_BITS),
  .PRIORITY_BITS (PRIORITY_BITS)
) u_spq_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .status          (status),
  .popped_tag      (popped_tag),
  .popped_priority (popped_priority),
  .occupancy       (occupancy)
);

`default_nettype wire

/* bench/stable_sorted_priority_queue_tb.sv */
// stable_sorted_priority_queue_tb: self-checking bench for the sorted priority queue
// a shadow queue predicts every push and pop, a monitor checks each result word
// depends on spq_pkg and stable_sorted_priority_queue
`timescale 1ns / 100ps

module stable_sorted_priority_queue_tb;

  import spq_pkg::*;

  localparam int DEPTH     = DefQueueDepth;
  localparam int TAG_W     = DefTagBits;
  localparam int PRI_W     = DefPriorityBits;
  localparam int OCC_W     = $clog2(DEPTH + 1);
  localparam int RAND_WORDS = 1550;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic             op;
    logic [TAG_W-1:0] tag;
    logic [PRI_W-1:0] pri;
    bit               wait_drain;
    bit               gap_ok;
  } queue_cmd_t;

  typedef struct {
    logic [STATUS_BITS-1:0] status;
    logic [TAG_W-1:0]       tag;
    logic [PRI_W-1:0]       pri;
    logic [OCC_W-1:0]       occ;
  } queue_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   opcode = OP_PUSH;
  logic [TAG_W-1:0]       entry_tag = '0;
  logic [PRI_W-1:0]       entry_priority = '0;
  logic                   busy;
  logic                   done;
  logic [STATUS_BITS-1:0] status;
  logic [TAG_W-1:0]       popped_tag;
  logic [PRI_W-1:0]       popped_priority;
  logic [OCC_W-1:0]       occupancy;

  stable_sorted_priority_queue dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .entry_tag(entry_tag),
    .entry_priority(entry_priority),
    .done(done),
    .status(status),
    .popped_tag(popped_tag),
    .popped_priority(popped_priority),
    .occupancy(occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  queue_cmd_t    cmds_to_send[$];
  queue_result_t results_due[$];

  // shadow copy of the sorted slots
  logic [TAG_W-1:0] shadow_tag[DEPTH];
  logic [PRI_W-1:0] shadow_pri[DEPTH];
  int               shadow_count = 0;

  int  mismatches = 0;
  int  cmds_taken = 0;
  int  idle_cycles = 0;
  int  n_stored = 0, n_dropped = 0, n_popped = 0, n_empty = 0, max_fill = 0;
  bit  taken = 1'b0;
  bit  gaps_allowed = 1'b1;
  bit  drain_next = 1'b0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // sorted insert after all entries of lower or equal priority, pop from the head
  task automatic apply_to_shadow_queue(input logic op, input logic [TAG_W-1:0] tag,
                                       input logic [PRI_W-1:0] pri,
                                       output queue_result_t res);
    int pos;
    res.status = ST_DONE;
    res.tag    = '0;
    res.pri    = '0;
    if (op == OP_PUSH) begin
      if (shadow_count >= DEPTH) begin
        res.status = ST_FULL;
        n_dropped++;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_pri[pos] <= pri) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_tag[i] = shadow_tag[i-1];
          shadow_pri[i] = shadow_pri[i-1];
        end
        shadow_tag[pos] = tag;
        shadow_pri[pos] = pri;
        shadow_count++;
        n_stored++;
      end
    end else if (shadow_count == 0) begin
      res.status = ST_EMPTY;
      n_empty++;
    end else begin
      res.tag = shadow_tag[0];
      res.pri = shadow_pri[0];
      for (int i = 1; i < shadow_count; i++) begin
        shadow_tag[i-1] = shadow_tag[i];
        shadow_pri[i-1] = shadow_pri[i];
      end
      shadow_count--;
      n_popped++;
    end
    if (shadow_count > max_fill) max_fill = shadow_count;
    res.occ = OCC_W'(shadow_count);
  endtask

  task automatic add_cmd(input logic op, input logic [TAG_W-1:0] tag,
                         input logic [PRI_W-1:0] pri);
    queue_cmd_t c;
    c.op = op;
    c.tag = tag;
    c.pri = pri;
    c.wait_drain = drain_next;
    c.gap_ok = gaps_allowed;
    drain_next = 1'b0;
    cmds_to_send.push_back(c);
  endtask

  // driver: new word at the falling edge once the previous one was taken
  always @(negedge clk) begin : driver
    queue_cmd_t c;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (cmds_to_send.size() != 0
          && !(cmds_to_send[0].wait_drain && results_due.size() != 0)
          && (!cmds_to_send[0].gap_ok || $urandom_range(99) >= 27)) begin
        c = cmds_to_send.pop_front();
        start          <= 1'b1;
        opcode         <= c.op;
        entry_tag      <= c.tag;
        entry_priority <= c.pri;
      end else begin
        start          <= 1'b0;
        opcode         <= 1'($urandom_range(1));
        entry_tag      <= TAG_W'($urandom);
        entry_priority <= PRI_W'($urandom);
      end
    end
  end

  // monitor: predict on acceptance, check each result word, watch for stalls
  always @(posedge clk) begin : monitor
    queue_result_t want;
    if (rst) begin
      taken = 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        apply_to_shadow_queue(opcode, entry_tag, entry_priority, want);
        results_due.push_back(want);
        cmds_taken++;
      end
      if (done) begin
        if (results_due.size() == 0) begin
          report_mismatch("result word with nothing outstanding, status", status, 0);
        end else begin
          want = results_due.pop_front();
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (popped_tag !== want.tag) report_mismatch("popped_tag", popped_tag, want.tag);
          if (popped_priority !== want.pri)
            report_mismatch("popped_priority", popped_priority, want.pri);
          if (occupancy !== want.occ) report_mismatch("occupancy", occupancy, want.occ);
        end
      end
      if (taken || done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no progress for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, results_due.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int total;
    int burst;
    int style;
    int push_pct;
    bit narrow;
    logic [PRI_W-1:0] pri_base;
    logic op;

    // empty pop, fill to full with ties and extremes, dropped push, refill
    add_cmd(OP_POP, 16'h0000, 8'h00);
    add_cmd(OP_PUSH, 16'h0000, 8'h80);
    add_cmd(OP_PUSH, 16'hFFFF, 8'h80);
    add_cmd(OP_PUSH, 16'h1234, 8'hFF);
    add_cmd(OP_PUSH, 16'h0001, 8'h00);
    add_cmd(OP_PUSH, 16'hABCD, 8'h80);
    add_cmd(OP_PUSH, 16'h5555, 8'h7F);
    add_cmd(OP_PUSH, 16'hAAAA, 8'h81);
    add_cmd(OP_PUSH, 16'h0002, 8'h00);
    add_cmd(OP_PUSH, 16'h00FF, 8'hFF);
    add_cmd(OP_PUSH, 16'hFF00, 8'h40);
    add_cmd(OP_PUSH, 16'h0F0F, 8'h80);
    add_cmd(OP_PUSH, 16'hF0F0, 8'hC0);
    add_cmd(OP_PUSH, 16'h3333, 8'h01);
    add_cmd(OP_PUSH, 16'hCCCC, 8'hFE);
    add_cmd(OP_PUSH, 16'h7777, 8'h80);
    add_cmd(OP_PUSH, 16'h8888, 8'h40);
    add_cmd(OP_PUSH, 16'hFFFF, 8'h00);
    add_cmd(OP_POP, 16'hFFFF, 8'hFF);
    add_cmd(OP_POP, 16'h0000, 8'h00);
    add_cmd(OP_PUSH, 16'h9999, 8'hFF);
    add_cmd(OP_PUSH, 16'h6666, 8'h00);
    add_cmd(OP_PUSH, 16'h4444, 8'h80);

    // random bursts that lean toward filling, draining or neither, mostly with clustered priorities
    drain_next = 1'b1;
    while (cmds_to_send.size() < RAND_WORDS + 23) begin
      burst    = $urandom_range(60, 10);
      style    = $urandom_range(9);
      narrow   = ($urandom_range(3) != 0);
      pri_base = PRI_W'($urandom);
      push_pct = (style <= 3) ? 75 : (style <= 6) ? 25 : 50;
      if ($urandom_range(15) == 0) drain_next = 1'b1;
      for (int k = 0; k < burst; k++) begin
        // one long stretch with the sender adding no random gaps
        gaps_allowed = !(cmds_to_send.size() >= 700 && cmds_to_send.size() < 1000);
        op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
        if (style == 9) add_cmd(1'($urandom_range(1)), TAG_W'($urandom), PRI_W'($urandom));
        else if (narrow) add_cmd(op, TAG_W'($urandom), pri_base + PRI_W'($urandom_range(3)));
        else add_cmd(op, TAG_W'($urandom), PRI_W'($urandom));
      end
    end
    total = cmds_to_send.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmds_taken < total || results_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("%0d words: %0d pushes stored, %0d dropped on full, %0d pops, %0d pops on empty",
             total, n_stored, n_dropped, n_popped, n_empty);
    $display("deepest fill %0d of %0d slots, %0d mismatches", max_fill, DEPTH, mismatches);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
